// File: rtl/credit_flow_control_table_unit_defines.svh
// Assertion macros for the credit table
`ifndef CREDIT_FLOW_CONTROL_TABLE_UNIT_DEFINES_SVH
`define CREDIT_FLOW_CONTROL_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CFCT_ASSERT_NOW(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("credit table check failed");

// next-cycle implication, checked outside reset
`define CFCT_ASSERT_NEXT(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("credit table check failed");

`endif

// File: rtl/cfct_pkg.sv
package cfct_pkg;

  localparam int DEF_PORT_COUNT = 5;
  localparam int DEF_NUM_VCS    = 4;

  localparam int PORT_W = 3;
  localparam int VC_W   = 3;
  localparam int CRED_W = 8;
  localparam int ACT_W  = 4;
  localparam int CNT_W  = 32;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 176;
  localparam int OUT_USED_W = 1 + CRED_W + 5 * CNT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PORTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VCS   = 2'd2;

  localparam logic [CRED_W-1:0] RST_CREDIT_LIMIT = 8'd4;
  localparam logic [ACT_W-1:0]  RST_ACTIVE_PORTS = 4'd5;
  localparam logic [ACT_W-1:0]  RST_ACTIVE_VCS   = 4'd4;

  typedef enum logic [1:0] {
    REQ_SEND   = 2'd0,
    REQ_RETURN = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_INIT   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_STALL = 2'd1,
    STAT_BAD   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  returns;
    logic [CNT_W-1:0]  stalls;
    logic [CNT_W-1:0]  sent;
    logic [CRED_W-1:0] ceiling;
    logic [CRED_W-1:0] credits;
  } entry_t;

endpackage

// File: rtl/credit_flow_control_table_unit.sv
// Credit table holding one credit counter and three event counters for every
// (port, virtual channel) pair in a single-port synchronous RAM. A send, return
// or check transaction is accepted together with the RAM read, then modified,
// written back and loaded into the result register once that register is free;
// no new item is taken until then. An init
// transaction sweeps the whole table, one entry a cycle, before its result is
// read back through FETCH and EXEC. The same sweep runs after reset,
// during which no input is taken (configuration writes are always taken).
// Configuration is meant to change only while the unit is idle; credit_limit,
// active_ports and active_vcs act only at the next init.
`include "credit_flow_control_table_unit_defines.svh"

module credit_flow_control_table_unit #(
  parameter int PORT_COUNT = cfct_pkg::DEF_PORT_COUNT,
  parameter int NUM_VCS    = cfct_pkg::DEF_NUM_VCS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // req_type
  input  logic [1:0]                      in_tuser,
  // port [2:0], vc [5:3], zero padding
  input  logic [cfct_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // status
  output logic [1:0]                      out_tuser,
  // can_send [0], credits_left [8:1], chan_flits_sent [40:9], chan_stalls [72:41],
  // chan_returns [104:73], all_flits_sent [136:105], all_stalls [168:137], padding
  output logic [cfct_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfct_pkg::*;

  localparam int NUM_CH = PORT_COUNT * NUM_VCS;
  localparam int AW     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int IDX_W  = PORT_W + VC_W;

  // configuration
  logic [CRED_W-1:0] credit_limit_r;
  logic [ACT_W-1:0]  active_ports_r;
  logic [ACT_W-1:0]  active_vcs_r;

  // FSM and latched item
  state_t            state_r, state_nxt;
  req_t              req_r;
  logic [AW-1:0]     addr_r;
  logic              chan_ok_r;
  logic              init_pend_r;

  // sweep position
  logic [AW-1:0]     sw_addr_r;
  logic [PORT_W-1:0] sw_port_r;
  logic [VC_W-1:0]   sw_vc_r;
  logic              sw_last;
  logic              sw_live;

  // RAM
  entry_t            mem [NUM_CH];
  entry_t            rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  // totals
  logic [CNT_W-1:0]  total_sent_r, total_sent_nxt;
  logic [CNT_W-1:0]  total_stall_r, total_stall_nxt;

  // output register
  logic                  out_valid_r;
  logic [1:0]            out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // input decode
  logic [PORT_W-1:0] in_port;
  logic [VC_W-1:0]   in_vc;
  logic              in_ok;
  logic [IDX_W-1:0]  in_idx;
  logic [AW-1:0]     in_addr;
  logic              accept;
  logic              exec_go;

  // execute datapath
  entry_t            upd;
  status_t           status_c;
  logic              modifies;

  assign in_port = in_tdata[PORT_W-1:0];
  assign in_vc   = in_tdata[PORT_W+VC_W-1:PORT_W];
  assign in_ok   = ({1'b0, in_port} < ACT_W'(PORT_COUNT)) && ({1'b0, in_vc} < ACT_W'(NUM_VCS));
  assign in_idx  = IDX_W'(in_port) * IDX_W'(NUM_VCS) + IDX_W'(in_vc);
  assign in_addr = in_ok ? in_idx[AW-1:0] : '0;
  assign accept  = in_tvalid && in_tready;
  assign exec_go = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  assign sw_last = (sw_addr_r == AW'(NUM_CH - 1));
  assign sw_live = ({1'b0, sw_port_r} < active_ports_r) && ({1'b0, sw_vc_r} < active_vcs_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_limit_r <= RST_CREDIT_LIMIT;
      active_ports_r <= RST_ACTIVE_PORTS;
      active_vcs_r   <= RST_ACTIVE_VCS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CREDIT_LIMIT: credit_limit_r <= cfg_data[CRED_W-1:0];
        CFG_ACTIVE_PORTS: active_ports_r <= cfg_data[ACT_W-1:0];
        CFG_ACTIVE_VCS:   active_vcs_r   <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sw_last) state_nxt = init_pend_r ? ST_FETCH : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = (req_t'(in_tuser) == REQ_INIT) ? ST_SWEEP : ST_EXEC;
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (exec_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = addr_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_en     = in_tvalid;
        rd_addr   = in_addr;
      end
      ST_FETCH: rd_en = 1'b1;
      default: ;
    endcase
  end

  // modify step
  always_comb begin
    upd             = rd_data_r;
    status_c        = STAT_DONE;
    modifies        = 1'b0;
    total_sent_nxt  = total_sent_r;
    total_stall_nxt = total_stall_r;
    case (req_r)
      REQ_SEND: begin
        modifies = 1'b1;
        if (rd_data_r.credits == '0) begin
          upd.stalls      = rd_data_r.stalls + 1'b1;
          total_stall_nxt = total_stall_r + 1'b1;
          status_c        = STAT_STALL;
        end else begin
          upd.credits    = rd_data_r.credits - 1'b1;
          upd.sent       = rd_data_r.sent + 1'b1;
          total_sent_nxt = total_sent_r + 1'b1;
        end
      end
      REQ_RETURN: begin
        if (rd_data_r.credits < rd_data_r.ceiling) begin
          modifies    = 1'b1;
          upd.credits = rd_data_r.credits + 1'b1;
          upd.returns = rd_data_r.returns + 1'b1;
        end else begin
          status_c = STAT_FULL;
        end
      end
      default: ;
    endcase
    if (!chan_ok_r) begin
      modifies        = 1'b0;
      status_c        = STAT_BAD;
      total_sent_nxt  = total_sent_r;
      total_stall_nxt = total_stall_r;
    end
  end

  // write port: sweep has priority, exec never overlaps it
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = addr_r;
    wr_data = upd;
    if (state_r == ST_SWEEP) begin
      mem_we          = 1'b1;
      wr_addr         = sw_addr_r;
      wr_data         = '0;
      wr_data.credits = sw_live ? credit_limit_r : '0;
      wr_data.ceiling = sw_live ? credit_limit_r : '0;
    end else if (exec_go && modifies) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      init_pend_r   <= 1'b0;
      sw_addr_r     <= '0;
      sw_port_r     <= '0;
      sw_vc_r       <= '0;
      total_sent_r  <= '0;
      total_stall_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SWEEP) begin
        if (sw_last) begin
          sw_addr_r <= '0;
          sw_port_r <= '0;
          sw_vc_r   <= '0;
        end else begin
          sw_addr_r <= sw_addr_r + 1'b1;
          if (sw_vc_r == VC_W'(NUM_VCS - 1)) begin
            sw_vc_r   <= '0;
            sw_port_r <= sw_port_r + 1'b1;
          end else begin
            sw_vc_r <= sw_vc_r + 1'b1;
          end
        end
      end
      if (accept) begin
        init_pend_r <= (req_t'(in_tuser) == REQ_INIT);
        if (req_t'(in_tuser) == REQ_INIT) begin
          total_sent_r  <= '0;
          total_stall_r <= '0;
        end
      end
      if (exec_go) begin
        total_sent_r  <= total_sent_nxt;
        total_stall_r <= total_stall_nxt;
        init_pend_r   <= 1'b0;
      end
      if (exec_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // item latch and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= req_t'(in_tuser);
      addr_r    <= in_addr;
      chan_ok_r <= in_ok;
    end
    if (exec_go) begin
      out_user_r <= status_c;
      if (chan_ok_r) begin
        out_data_r <= OUT_DATA_W'({total_stall_nxt, total_sent_nxt, upd.returns, upd.stalls,
                                   upd.sent, upd.credits, (upd.credits != '0)});
      end else begin
        out_data_r <= OUT_DATA_W'({total_stall_nxt, total_sent_nxt,
                                   (OUT_USED_W - 2 * CNT_W)'(0)});
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  `CFCT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_tready)
  `CFCT_ASSERT_NOW(a_no_write_bad_chan, clk, rst_n, mem_we && (state_r == ST_EXEC), chan_ok_r)
  `CFCT_ASSERT_NOW(a_credit_in_ceiling, clk, rst_n, mem_we, wr_data.credits <= wr_data.ceiling)
  `CFCT_ASSERT_NEXT(a_sweep_leaves, clk, rst_n, (state_r == ST_SWEEP) && sw_last,
                    (state_r == ST_FETCH) || (state_r == ST_IDLE))

endmodule
